// ===== sv/hdp_pkg.sv =====
// Shared types, constants and lookup functions for the HTTP date parser.
package hdp_pkg;

  localparam logic [5:0] POS_LEAD     = 6'd0;
  localparam logic [5:0] POS_WD1      = 6'd1;
  localparam logic [5:0] POS_WD2      = 6'd2;
  localparam logic [5:0] POS_DISPATCH = 6'd3;
  localparam logic [5:0] POS_BASE     = 6'd4;
  localparam logic [5:0] POS_TRAIL    = 6'd63;

  localparam logic [2:0] WEEKDAY_NONE = 3'd7;

  localparam logic [1:0] FMT_ISO     = 2'd0;
  localparam logic [1:0] FMT_RFC1123 = 2'd1;
  localparam logic [1:0] FMT_ASCTIME = 2'd2;
  localparam logic [1:0] FMT_RFC850  = 2'd3;

  localparam logic [8*19-1:0] TPL_ISO     = "YYYY-oo-ddThh:mm:ss";
  localparam logic [8*26-1:0] TPL_RFC1123 = ", de nnn YYYY hh:mm:ss GMT";
  localparam logic [8*21-1:0] TPL_ASCTIME = " nnn ad hh:mm:ss YYYY";
  localparam logic [8*25-1:0] TPL_RFC850  = "*, dd-nnn-yy hh:mm:ss GMT";

  localparam logic [8*21-1:0] WD_NAMES  = "SunMonTueWedThuFriSat";
  localparam logic [8*36-1:0] MON_NAMES = "JanFebMarAprMayJunJulAugSepOctNovDec";

  typedef struct packed {
    logic parse;
    logic step1;
    logic step2;
    logic step3;
    logic step4;
  } hdp_cmd_t;

  typedef struct packed {
    logic out_pending;
  } hdp_status_t;

  function automatic logic [4:0] tpl_len(input logic [1:0] f);
    logic [4:0] n;
    case (f)
      FMT_ISO:     n = 5'd19;
      FMT_RFC1123: n = 5'd26;
      FMT_ASCTIME: n = 5'd21;
      default:     n = 5'd25;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] tpl_at(input logic [1:0] f, input logic [5:0] t);
    logic [7:0] ch;
    ch = 8'h00;
    case (f)
      FMT_ISO:     if (t < 6'd19) ch = TPL_ISO[8*(18-t) +: 8];
      FMT_RFC1123: if (t < 6'd26) ch = TPL_RFC1123[8*(25-t) +: 8];
      FMT_ASCTIME: if (t < 6'd21) ch = TPL_ASCTIME[8*(20-t) +: 8];
      default:     if (t < 6'd25) ch = TPL_RFC850[8*(24-t) +: 8];
    endcase
    return ch;
  endfunction

  // Bit 3 set means no weekday matched.
  function automatic logic [3:0] wd_match(input logic [15:0] np, input logic [7:0] c);
    logic [3:0] k;
    k = 4'd8;
    for (int i = 6; i >= 0; i--) begin
      if (WD_NAMES[8*3*(6-i) +: 24] == {np, c}) k = 4'(i);
    end
    return k;
  endfunction

  // Month number 1 to 12, or zero when nothing matched.
  function automatic logic [3:0] mon_match(input logic [15:0] np, input logic [7:0] c);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 11; i >= 0; i--) begin
      if (MON_NAMES[8*3*(11-i) +: 24] == {np, c}) k = 4'(i + 1);
    end
    return k;
  endfunction

  function automatic logic [2:0] tail_len(input logic [2:0] w);
    logic [2:0] n;
    case (w)
      3'd0, 3'd1, 3'd5: n = 3'd3;
      3'd2:             n = 3'd4;
      3'd3:             n = 3'd6;
      3'd4, 3'd6:       n = 3'd5;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] tail_at(input logic [2:0] w, input logic [2:0] j);
    logic [8*6-1:0] s;
    logic [7:0]     ch;
    case (w)
      3'd0, 3'd1, 3'd5: s = {"day", 24'h0};
      3'd2:             s = {"sday", 16'h0};
      3'd3:             s = "nesday";
      3'd4:             s = {"rsday", 8'h0};
      3'd6:             s = {"urday", 8'h0};
      default:          s = '0;
    endcase
    ch = 8'h00;
    if (j < 3'd6) ch = s[8*(5-j) +: 8];
    return ch;
  endfunction

  function automatic logic [4:0] mon_days(input logic [3:0] mo);
    logic [4:0] n;
    case (mo)
      4'd2:                   n = 5'd29;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] mon_before(input logic [3:0] mo);
    logic [8:0] n;
    case (mo)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Remainder by seven, folding octal digits since eight is one more than seven.
  function automatic logic [2:0] mod7(input logic [23:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = '0;
    for (int i = 0; i < 8; i++) s1 = s1 + 6'(x[3*i +: 3]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd7) s2 = s2 - 4'd7;
    if (s2 >= 4'd7) s2 = s2 - 4'd7;
    return s2[2:0];
  endfunction

endpackage

// ===== sv/http_date_parser_core.sv =====
// Top level of the HTTP date parser: controller and datapath.
//  channel | direction | handshake           | payload
//  input   | in        | in_valid / in_stall | char_code, end_of_text
//  result  | out       | out_valid/out_stall | ok, format_kind, unix_time
//  config  | in        | cfg_wr_en           | cfg_wr_data (relaxed_day)
// A character word is taken every cycle while input does not stall; it is parsed in the cycle it arrives.
// An end word starts a conversion in the datapath, during which input stalls.
// The result sits in an output register; characters keep flowing while it waits,
// but a further end word stalls until the result has been taken.
// Reset is synchronous and clears the parse state, the relaxed_day register and the result valid.
module http_date_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  input  logic               end_of_text,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic [1:0]         format_kind,
  output logic signed [38:0] unix_time
);
  import hdp_pkg::*;

  hdp_cmd_t    cmd;
  hdp_status_t status;

  hdp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .end_of_text (end_of_text),
    .status      (status),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  hdp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .format_kind (format_kind),
    .unix_time   (unix_time)
  );
endmodule

// ===== sv/hdp_ctrl.sv =====
// Controller state machine sequencing character parsing and the conversion steps.
module hdp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                end_of_text,
  input  hdp_pkg::hdp_status_t status,
  output logic                in_stall,
  output hdp_pkg::hdp_cmd_t   cmd
);
  import hdp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_C1   = 5'b00010,
    ST_C2   = 5'b00100,
    ST_C3   = 5'b01000,
    ST_C4   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE) || (status.out_pending && end_of_text);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && end_of_text) state_next = ST_C1;
      ST_C1:   state_next = ST_C2;
      ST_C2:   state_next = ST_C3;
      ST_C3:   state_next = ST_C4;
      ST_C4:   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd.parse = accept && !end_of_text;
    cmd.step1 = (state == ST_C1);
    cmd.step2 = (state == ST_C2);
    cmd.step3 = (state == ST_C3);
    cmd.step4 = (state == ST_C4);
  end

`ifndef SYNTHESIS
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |-> ##4 cmd.step4) else $error("result step missed");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.step4 |-> !status.out_pending) else $error("result overwritten");
  a_busy_no_parse: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !cmd.parse) else $error("parse during conversion");
`endif
endmodule

// ===== sv/hdp_datapath.sv =====
// Datapath holding the parse state, the date conversion steps and the result register.
module hdp_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  hdp_pkg::hdp_cmd_t    cmd,
  output hdp_pkg::hdp_status_t status,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic [7:0]           char_code,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 ok,
  output logic [1:0]           format_kind,
  output logic signed [38:0]   unix_time
);
  import hdp_pkg::*;

  logic        relaxed;
  logic [5:0]  pos, pos_next;
  logic [1:0]  fmt, fmt_next;
  logic        failed, failed_next;
  logic [15:0] np, np_next;
  logic [2:0]  wd, wd_next;
  logic [13:0] yr, yr_next;
  logic [6:0]  mo, mo_next, dy, dy_next, hr, hr_next, mi, mi_next, se, se_next;

  logic        dig, run_tpl, hit;
  logic [3:0]  dv, wm, mm;
  logic [1:0]  tf;
  logic [5:0]  tp, t, nx;
  logic [4:0]  len;
  logic [7:0]  code;
  logic [13:0] yacc;
  logic [15:0] npi;

  assign dig = (char_code >= "0") && (char_code <= "9");
  assign dv  = dig ? 4'(char_code - "0") : 4'd0;

  always_comb begin
    pos_next = pos; fmt_next = fmt; failed_next = failed; np_next = np; wd_next = wd;
    yr_next = yr; mo_next = mo; dy_next = dy; hr_next = hr; mi_next = mi; se_next = se;
    run_tpl = 1'b0; tf = fmt; tp = pos; t = '0; nx = '0; len = '0; code = '0;
    hit = 1'b1; wm = '0; mm = '0; yacc = '0; npi = '0;
    case (pos)
      POS_LEAD: begin
        if (char_code == " ") begin
          run_tpl = 1'b0;
        end else if (dig) begin
          fmt_next = FMT_ISO; tf = FMT_ISO; tp = POS_BASE; run_tpl = 1'b1;
        end else begin
          np_next = {8'h00, char_code}; pos_next = POS_WD1;
        end
      end
      POS_WD1: begin
        np_next = {np[7:0], char_code}; pos_next = POS_WD2;
      end
      POS_WD2: begin
        wm = wd_match(np, char_code);
        if (wm[3]) failed_next = 1'b1;
        else begin
          wd_next = wm[2:0]; np_next = '0; pos_next = POS_DISPATCH;
        end
      end
      POS_DISPATCH: begin
        tf = (char_code == ",") ? FMT_RFC1123 : ((char_code == " ") ? FMT_ASCTIME : FMT_RFC850);
        fmt_next = tf; tp = POS_BASE; run_tpl = 1'b1;
      end
      POS_TRAIL: if (char_code != " ") failed_next = 1'b1;
      default: run_tpl = 1'b1;
    endcase
    if (run_tpl) begin
      t   = tp - POS_BASE;
      len = tpl_len(tf);
      if (tp < POS_BASE || t >= {1'b0, len}) begin
        hit = 1'b0;
      end else begin
        code = tpl_at(tf, t);
        nx   = t + 6'd1;
        if (code inside {"Y", "y", "o", "d", "h", "m", "s"}) begin
          if (!dig) hit = 1'b0;
          else begin
            case (code)
              "Y", "y": begin
                yacc = 14'(yr * 14'd10 + 14'(dv));
                if (code == "y" && tpl_at(tf, nx) != "y") begin
                  yacc = yacc + 14'd1900;
                  if (yacc < 14'd1969) yacc = yacc + 14'd100;
                end
                yr_next = yacc;
              end
              "o":     mo_next = 7'(mo * 7'd10 + 7'(dv));
              "d":     dy_next = 7'(dy * 7'd10 + 7'(dv));
              "h":     hr_next = 7'(hr * 7'd10 + 7'(dv));
              "m":     mi_next = 7'(mi * 7'd10 + 7'(dv));
              default: se_next = 7'(se * 7'd10 + 7'(dv));
            endcase
          end
        end else begin
          case (code)
            "e": begin
              if (char_code == " " && relaxed) nx = t + 6'd2;
              else if (dig) dy_next = 7'(dy * 7'd10 + 7'(dv));
              else hit = 1'b0;
            end
            "a": begin
              if (dig) dy_next = 7'(dv);
              else if (char_code != " ") hit = 1'b0;
            end
            "n": begin
              if (tpl_at(tf, nx) == "n") np_next = {np[7:0], char_code};
              else begin
                mm = mon_match(np, char_code);
                if (mm == 4'd0) hit = 1'b0;
                else begin
                  mo_next = 7'(mm); np_next = '0;
                end
              end
            end
            "*": begin
              if (wd > 3'd6 || np >= 16'(tail_len(wd)) || tail_at(wd, np[2:0]) != char_code) begin
                hit = 1'b0;
              end else begin
                npi = np + 16'd1;
                if (npi < 16'(tail_len(wd))) begin
                  np_next = npi; nx = t;
                end else begin
                  np_next = '0;
                end
              end
            end
            default: if (code != char_code) hit = 1'b0;
          endcase
        end
      end
      if (!hit) failed_next = 1'b1;
      else pos_next = (nx >= 6'(len)) ? POS_TRAIL : POS_BASE + nx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) relaxed <= 1'b0;
    else if (cfg_wr_en) relaxed <= cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.step4) begin
      pos <= POS_LEAD; fmt <= FMT_ISO; failed <= 1'b0; np <= '0; wd <= WEEKDAY_NONE;
      yr <= '0; mo <= '0; dy <= '0; hr <= '0; mi <= '0; se <= '0;
    end else if (cmd.parse && !failed) begin
      pos <= pos_next; fmt <= fmt_next; failed <= failed_next; np <= np_next;
      wd <= wd_next; yr <= yr_next; mo <= mo_next; dy <= dy_next;
      hr <= hr_next; mi <= mi_next; se <= se_next;
    end
  end

  // Conversion: year split, day count, weekday check, seconds.
  logic [26:0]        pq, pqm;
  logic [13:0]        ym1, rfull;
  logic [6:0]         cq, cqm, r;
  logic [10:0]        hm;
  logic [16:0]        ctod;
  logic [6:0]         sx;
  logic               ok1, cok1, leap, ok2, cok2, cok3;
  logic [23:0]        dcalc, cd, rq;
  logic [2:0]         m7;
  logic signed [38:0] cdsec;

  assign ym1 = yr - 14'd1;
  assign pq  = 27'(yr) * 27'd5243;
  assign pqm = 27'(ym1) * 27'd5243;
  assign sx  = (se == 7'd60) ? 7'd59 : se;
  assign hm  = 11'(hr) * 11'd60 + 11'(mi);
  assign ok1 = !failed && pos == POS_TRAIL && se <= 7'd60 && mi <= 7'd59 && hr <= 7'd23
             && mo >= 7'd1 && mo <= 7'd12 && dy >= 7'd1
             && dy <= 7'(mon_days(mo[3:0])) && yr >= 14'd1899;

  assign rfull = yr - 14'(cq) * 14'd100;
  assign r     = rfull[6:0];
  assign leap  = (yr[1:0] == 2'd0) && (r != 7'd0 || cq[1:0] == 2'd0);
  assign ok2   = cok1 && !(mo == 7'd2 && dy > 7'd28 && !leap);
  assign rq    = (r != 7'd0) ? 24'((r - 7'd1) >> 2) : 24'd0;
  assign dcalc = 24'(dy) + 24'(mon_before(mo[3:0])) + 24'(leap && mo > 7'd2)
               + 24'(r) * 24'd365 + rq + 24'(cq) * 24'd36524 + 24'(cqm[6:2])
               - 24'd730485;
  assign m7    = mod7(cd + 24'd70006);

  always_ff @(posedge clk) begin
    if (cmd.step1) begin
      cq   <= pq[25:19];
      cqm  <= pqm[25:19];
      ctod <= 17'(hm) * 17'd60 + 17'(sx);
      cok1 <= ok1;
    end
    if (cmd.step2) begin
      cd   <= dcalc;
      cok2 <= ok2;
    end
    if (cmd.step3) begin
      cdsec <= $signed(cd) * 39'sd86400;
      cok3  <= cok2 && (wd == WEEKDAY_NONE || m7 == wd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.step4) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.step4) begin
      ok          <= cok3;
      format_kind <= cok3 ? fmt : FMT_ISO;
      unix_time   <= cok3 ? (cdsec + $signed({22'd0, ctod}) + 39'sd946684800) : 39'sd0;
    end
  end

  assign status.out_pending = out_valid;
endmodule

// ===== dv/tb_http_date_parser_core.sv =====
// Self-checking testbench for the HTTP date parser: directed and random date strings.
module tb_http_date_parser_core;
  import hdp_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic               cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         char_code;
  logic               end_of_text;
  logic               out_valid;
  logic               out_stall;
  logic               ok;
  logic [1:0]         format_kind;
  logic signed [38:0] unix_time;

  typedef struct {
    logic               ok;
    logic [1:0]         kind;
    logic signed [38:0] secs;
  } date_result_t;

  date_result_t pending_dates[$];
  int unsigned  mismatch_count;
  int unsigned  dates_checked;
  int unsigned  valid_dates;
  int unsigned  cycle_count;

  // Predictor state.
  logic        relaxed_mode;
  logic [5:0]  pos;
  logic [1:0]  layout;
  logic        bad;
  logic [15:0] prefix;
  logic [2:0]  wday;
  int          yr, mon, mday, hr, mnt, sec;

  http_date_parser_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .char_code(char_code),
    .end_of_text(end_of_text), .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .format_kind(format_kind), .unix_time(unix_time)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic string layout_text(input logic [1:0] f);
    case (f)
      FMT_ISO:     return "YYYY-oo-ddThh:mm:ss";
      FMT_RFC1123: return ", de nnn YYYY hh:mm:ss GMT";
      FMT_ASCTIME: return " nnn ad hh:mm:ss YYYY";
      default:     return "*, dd-nnn-yy hh:mm:ss GMT";
    endcase
  endfunction

  function automatic string day_tail(input logic [2:0] w);
    case (w)
      3'd2:    return "sday";
      3'd3:    return "nesday";
      3'd4:    return "rsday";
      3'd6:    return "urday";
      default: return "day";
    endcase
  endfunction

  function automatic int find_name(input string names, input int n, input logic [7:0] c);
    for (int i = 0; i < n; i++) begin
      if (names[3*i] == prefix[15:8] && names[3*i+1] == prefix[7:0] && names[3*i+2] == c)
        return i;
    end
    return -1;
  endfunction

  task automatic clear_date();
    pos = POS_LEAD;
    layout = FMT_ISO;
    bad = 1'b0;
    prefix = '0;
    wday = WEEKDAY_NONE;
    yr = 0; mon = 0; mday = 0; hr = 0; mnt = 0; sec = 0;
  endtask

  task automatic layout_char(input logic [7:0] c);
    string tp;
    int    len, t, nxt, dv, k;
    bit    dig;
    byte   code;
    string tl;
    tp = layout_text(layout);
    len = tp.len();
    dig = c >= "0" && c <= "9";
    dv = dig ? c - "0" : 0;
    if (pos < POS_BASE || pos - POS_BASE >= len) begin
      bad = 1'b1;
      return;
    end
    t = pos - POS_BASE;
    code = tp[t];
    nxt = t + 1;
    case (code)
      "Y", "y", "o", "d", "h", "m", "s": begin
        if (!dig) begin
          bad = 1'b1;
          return;
        end
        case (code)
          "Y", "y": begin
            yr = yr * 10 + dv;
            if (code == "y" && (nxt >= len || tp[nxt] != "y")) begin
              yr += 1900;
              if (yr < 1969) yr += 100;
            end
          end
          "o": mon = mon * 10 + dv;
          "d": mday = mday * 10 + dv;
          "h": hr = hr * 10 + dv;
          "m": mnt = mnt * 10 + dv;
          default: sec = sec * 10 + dv;
        endcase
      end
      "e": begin
        if (c == " " && relaxed_mode) nxt = t + 2;
        else if (dig) mday = mday * 10 + dv;
        else begin
          bad = 1'b1;
          return;
        end
      end
      "a": begin
        if (dig) mday = dv;
        else if (c != " ") begin
          bad = 1'b1;
          return;
        end
      end
      "n": begin
        if (nxt < len && tp[nxt] == "n") begin
          prefix = {prefix[7:0], c};
        end else begin
          k = find_name("JanFebMarAprMayJunJulAugSepOctNovDec", 12, c);
          if (k < 0) begin
            bad = 1'b1;
            return;
          end
          mon = k + 1;
          prefix = '0;
        end
      end
      "*": begin
        if (wday > 3'd6) begin
          bad = 1'b1;
          return;
        end
        tl = day_tail(wday);
        if (prefix >= tl.len() || tl[prefix] != c) begin
          bad = 1'b1;
          return;
        end
        prefix++;
        if (prefix < tl.len()) nxt = t;
        else prefix = '0;
      end
      default: begin
        if (code != c) begin
          bad = 1'b1;
          return;
        end
      end
    endcase
    pos = nxt >= len ? POS_TRAIL : 6'(POS_BASE + nxt);
  endtask

  function automatic date_result_t convert_date();
    date_result_t r;
    longint y, d, s;
    bit leap;
    int mdays[12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int mbefore[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    r.ok = 1'b0;
    r.kind = FMT_ISO;
    r.secs = '0;
    y = yr;
    s = sec;
    if (bad || pos != POS_TRAIL) return r;
    if (sec > 60 || mnt > 59 || hr > 23 || mon < 1 || mon > 12) return r;
    if (mday < 1 || mday > mdays[mon-1] || y < 1899) return r;
    leap = (y % 4) == 0 && ((y % 100) != 0 || (y % 400) == 0);
    if (mon == 2 && mday > 28 && !leap) return r;
    if (s == 60) s = 59;
    d = (mday - 1) + mbefore[mon-1];
    if (mon > 2 && leap) d++;
    d += (y % 100) * 365;
    if ((y % 100) > 0) d += ((y % 100) - 1) / 4;
    d += ((y / 100) - 20) * (100 * 365 + 24);
    d += ((y - 1) / 400) - 4;
    if (wday != WEEKDAY_NONE && (d + 6 + 7 * 10000) % 7 != wday) return r;
    r.ok = 1'b1;
    r.kind = layout;
    r.secs = 39'((longint'(hr) * 60 + mnt) * 60 + s + d * 86400 + 10957 * 86400);
    return r;
  endfunction

  task automatic predict_word(input logic [7:0] c, input logic eot);
    int k;
    if (eot) begin
      pending_dates.push_back(convert_date());
      clear_date();
      return;
    end
    if (bad) return;
    case (pos)
      POS_LEAD: begin
        if (c == " ") return;
        if (c >= "0" && c <= "9") begin
          layout = FMT_ISO;
          pos = POS_BASE;
          layout_char(c);
        end else begin
          prefix = {8'h00, c};
          pos = POS_WD1;
        end
      end
      POS_WD1: begin
        prefix = {prefix[7:0], c};
        pos = POS_WD2;
      end
      POS_WD2: begin
        k = find_name("SunMonTueWedThuFriSat", 7, c);
        if (k < 0) bad = 1'b1;
        else begin
          wday = 3'(k);
          prefix = '0;
          pos = POS_DISPATCH;
        end
      end
      POS_DISPATCH: begin
        layout = c == "," ? FMT_RFC1123 : (c == " " ? FMT_ASCTIME : FMT_RFC850);
        pos = POS_BASE;
        layout_char(c);
      end
      POS_TRAIL: if (c != " ") bad = 1'b1;
      default: layout_char(c);
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Sends one word after a random gap and updates the prediction when it is taken.
  task automatic send_word(input logic [7:0] c, input logic eot);
    int unsigned gap;
    gap = $urandom_range(0, 12) * ($urandom_range(0, 3) == 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    predict_word(c, eot);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    send_word($urandom_range(0, 255), 1'b1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_relaxed(input logic v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    relaxed_mode = v;
  endtask

  // Result checker: each result word is held for a random number of cycles.
  initial begin
    date_result_t want;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (!rst && out_valid) begin
        repeat ($urandom_range(0, 12)) @(negedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
        if (pending_dates.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          want = pending_dates.pop_front();
          dates_checked++;
          if (want.ok) valid_dates++;
          if (ok !== want.ok) report_mismatch("ok", ok, want.ok);
          if (format_kind !== want.kind) report_mismatch("format_kind", format_kind, want.kind);
          if (unix_time !== want.secs) report_mismatch("unix_time", unix_time, want.secs);
        end
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 900000) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic string two(input int v);
    return $sformatf("%02d", v);
  endfunction

  function automatic string good_date(input int f);
    string wds, mons, s;
    int y, m, d, w;
    y = $urandom_range(0, 7) == 0 ? $urandom_range(1899, 9999) : $urandom_range(1960, 2070);
    if (f == 3) y = $urandom_range(1969, 2068);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, 31);
    w = $urandom_range(0, 6);
    wds = "SunMonTueWedThuFriSat";
    mons = "JanFebMarAprMayJunJulAugSepOctNovDec";
    case (f)
      0: s = $sformatf("%04d-%s-%sT%s:%s:%s", y, two(m), two(d), two($urandom_range(0, 24)),
                       two($urandom_range(0, 60)), two($urandom_range(0, 61)));
      1: s = $sformatf("%s, %s %s %04d %s:%s:%s GMT", wds.substr(3*w, 3*w+2), two(d),
                       mons.substr(3*m-3, 3*m-1), y, two($urandom_range(0, 23)),
                       two($urandom_range(0, 59)), two($urandom_range(0, 60)));
      2: s = $sformatf("%s %s %2d %s:%s:%s %04d", wds.substr(3*w, 3*w+2),
                       mons.substr(3*m-3, 3*m-1), d, two($urandom_range(0, 23)),
                       two($urandom_range(0, 59)), two($urandom_range(0, 60)), y);
      default: s = $sformatf("%s%s, %s-%s-%s %s:%s:%s GMT", wds.substr(3*w, 3*w+2),
                       day_tail(3'(w)), two(d), mons.substr(3*m-3, 3*m-1), two(y % 100),
                       two($urandom_range(0, 23)), two($urandom_range(0, 59)),
                       two($urandom_range(0, 60)));
    endcase
    return s;
  endfunction

  task automatic test_directed();
    send_text("1994-11-06T08:49:37");
    send_text("   Sun, 06 Nov 1994 08:49:37 GMT   ");
    send_text("Sun Nov  6 08:49:37 1994");
    send_text("Sunday, 06-Nov-94 08:49:37 GMT");
    send_text("Wednesday, 01-Jan-25 00:00:00 GMT");
    send_text("Thursday, 01-Jan-70 00:00:00 GMT");
    send_text("");
    send_text("    ");
    send_text("1994-11-06T08:49");
    send_text("1898-12-31T23:59:59");
    send_text("1899-01-01T00:00:00");
    send_text("9999-12-31T23:59:60");
    send_text("2000-02-29T12:00:00");
    send_text("1900-02-29T12:00:00");
    send_text("Mon, 06 Nov 1994 08:49:37 GMT");
    send_text("Sun, 6 Nov 1994 08:49:37 GMT");
    send_text("1994-11-06T08:49:37 x");
    send_text({"1994-11", 8'h00, "06T08:49:37"});
    send_word(8'hff, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7f, 1'b0);
    send_word($urandom_range(0, 255), 1'b1);
    send_word(8'h00, 1'b0);
    send_word($urandom_range(0, 255), 1'b1);
  endtask

  task automatic test_relaxed_day();
    write_relaxed(1'b1);
    send_text("Sun, 6 Nov 1994 08:49:37 GMT");
    send_text("Sun, 06 Nov 1994 08:49:37 GMT");
    send_text("Thu, 1 Jan 1970 00:00:00 GMT");
  endtask

  task automatic test_random(input int unsigned words);
    int unsigned sent;
    string s;
    int p;
    sent = 0;
    while (sent < words) begin
      s = good_date($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: begin
          p = $urandom_range(0, s.len() - 1);
          s[p] = 8'($urandom_range(0, 255));
        end
        1: s = s.substr(0, $urandom_range(0, s.len() - 1));
        2: s = {"  ", s, "  "};
        default: ;
      endcase
      if ($urandom_range(0, 19) == 0) begin
        s = "";
        repeat ($urandom_range(0, 8)) s = {s, 8'($urandom_range(0, 255))};
      end
      send_text(s);
      sent += s.len() + 1;
      if ($urandom_range(0, 29) == 0) drain_results();
      if ($urandom_range(0, 99) == 0) write_relaxed($urandom_range(0, 1));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    char_code = '0;
    end_of_text = 1'b0;
    mismatch_count = 0;
    dates_checked = 0;
    valid_dates = 0;
    relaxed_mode = 1'b0;
    clear_date();
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_relaxed_day();
    write_relaxed(1'b0);
    test_random(250);
    write_relaxed(1'b1);
    test_random(150);
    drain_results();
    $display("checked %0d results, %0d of them valid dates, over four layouts",
             dates_checked, valid_dates);
    $display("with day relaxation both off and on");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
